FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the filter RTL.
// Same-cycle and next-cycle implication checks, disabled during reset.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/bqd_pkg.sv
// ---------------------------------------------------------------------------
// bqd_pkg
// Constants, sequencer states and control types of the biquad filter unit.
// ---------------------------------------------------------------------------
package bqd_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int CHANNELS_DEF    = 8;
  localparam int CHAN_BITS       = 3;
  localparam int COEF_BITS       = 32;
  localparam int COEF_FRAC       = 28;
  localparam int GUARD_BITS      = 16;
  localparam int STATE_EXTRA     = 24;   // state width over sample width
  localparam int NUM_COEFS       = 5;
  localparam int CFG_IDX_BITS    = 3;
  localparam int MUL_BITS        = 32;
  localparam int PROD_BITS       = 2 * MUL_BITS;
  localparam int ACC_BITS        = PROD_BITS;
  localparam int X_SHIFT         = COEF_FRAC - GUARD_BITS;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M0,
    ST_Y,
    ST_S1A,
    ST_S1B,
    ST_S1C,
    ST_S2A,
    ST_S2B,
    ST_S2C,
    ST_DONE
  } seq_state_t;

  // register indexes, also used as coefficient select
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CF_B0,
    CF_B1,
    CF_B2,
    CF_A1,
    CF_A2
  } coef_sel_t;

  typedef enum logic [1:0] {
    OPND_X,
    OPND_YH,
    OPND_YL
  } opnd_t;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_Y,
    ACC_LOAD_D2,
    ACC_LOAD_X,
    ACC_SUB_HI,
    ACC_SUB_LO
  } acc_op_t;

  typedef struct packed {
    logic      mul_en;
    coef_sel_t coef_sel;
    opnd_t     opnd;
    acc_op_t   acc_op;
    logic      read_en;
    logic      s1_save;
    logic      finish;
  } ctl_t;

endpackage

FILE: rtl/core/bqd_ifs.sv
// ---------------------------------------------------------------------------
// bqd channel interfaces
// Valid/ready channels for input samples, output samples and register writes.
// ---------------------------------------------------------------------------
interface bqd_in_if #(parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF);
  import bqd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [CHAN_BITS-1:0]          chan;

  modport source (output valid, output sample_in, output chan, input ready);
  modport sink   (input valid, input sample_in, input chan, output ready);
endinterface

interface bqd_out_if #(parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF);
  import bqd_pkg::*;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [CHAN_BITS-1:0]          chan_out;

  modport source (output valid, output sample_out, output chan_out, input ready);
  modport sink   (input valid, input sample_out, input chan_out, output ready);
endinterface

interface bqd_cfg_if;
  import bqd_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [COEF_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/bqd_mul.sv
// ---------------------------------------------------------------------------
// bqd_mul
// Shared signed 32x32 multiplier with a registered product.
// ---------------------------------------------------------------------------
module bqd_mul (
  input  logic                                   clk,
  input  logic                                   en,
  input  logic signed [bqd_pkg::MUL_BITS-1:0]    coef,
  input  logic signed [bqd_pkg::MUL_BITS-1:0]    opnd,
  output logic signed [bqd_pkg::PROD_BITS-1:0]   prod
);
  import bqd_pkg::*;

  // full-width signed product, held until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= coef * opnd;
    end
  end

endmodule

FILE: rtl/core/bqd_seq.sv
// ---------------------------------------------------------------------------
// bqd_seq
// Step sequencer: schedules the seven products and the accumulator ops.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bqd_seq (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic          out_free,
  output logic          ready,
  output bqd_pkg::ctl_t ctl
);
  import bqd_pkg::*;

  seq_state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (start) state_next = ST_M0;
      ST_M0:   state_next = ST_Y;
      ST_Y:    state_next = ST_S1A;
      ST_S1A:  state_next = ST_S1B;
      ST_S1B:  state_next = ST_S1C;
      ST_S1C:  state_next = ST_S2A;
      ST_S2A:  state_next = ST_S2B;
      ST_S2B:  state_next = ST_S2C;
      ST_S2C:  state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // step outputs: multiply issued this step, accumulate of last product
  always_comb begin
    ready        = 1'b0;
    ctl          = '0;
    ctl.coef_sel = CF_B0;
    ctl.opnd     = OPND_X;
    ctl.acc_op   = ACC_HOLD;
    case (state)
      ST_IDLE: begin
        ready = 1'b1;
      end
      ST_M0: begin
        ctl.mul_en  = 1'b1;
        ctl.read_en = 1'b1;
      end
      ST_Y: begin
        ctl.acc_op   = ACC_Y;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_B1;
      end
      ST_S1A: begin
        ctl.acc_op   = ACC_LOAD_D2;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_A1;
        ctl.opnd     = OPND_YH;
      end
      ST_S1B: begin
        ctl.acc_op   = ACC_SUB_HI;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_A1;
        ctl.opnd     = OPND_YL;
      end
      ST_S1C: begin
        ctl.acc_op   = ACC_SUB_LO;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_B2;
      end
      ST_S2A: begin
        ctl.acc_op   = ACC_LOAD_X;
        ctl.s1_save  = 1'b1;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_A2;
        ctl.opnd     = OPND_YH;
      end
      ST_S2B: begin
        ctl.acc_op   = ACC_SUB_HI;
        ctl.mul_en   = 1'b1;
        ctl.coef_sel = CF_A2;
        ctl.opnd     = OPND_YL;
      end
      ST_S2C: begin
        ctl.acc_op = ACC_SUB_LO;
      end
      ST_DONE: begin
        ctl.finish = out_free;
      end
      default: begin
        ready = 1'b0;
      end
    endcase
  end

  `ASSERT_NEXT(a_start_busy, clk, rst, start, !ready, "sequencer ready right after a start")
  `ASSERT_NEXT(a_done_wait, clk, rst, (state == ST_DONE) && !out_free, state == ST_DONE, "left done while output busy")

endmodule

FILE: rtl/core/biquad_tdf2_filter_unit.sv
// The single 32x32 multiplier issues seven products in seven steps, then come one
//   accumulate, one write-back and one idle accept step; a new sample is accepted
//   only in the idle step, so one sample is processed at a time.
// A stalled output holds the unit in its last step until the beat is taken.
// Reset: coefficients clear to zero, all channel states read as zero (valid bits).
// ---------------------------------------------------------------------------
// biquad_tdf2_filter_unit
// Multichannel transposed direct form II biquad on one shared multiplier.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module biquad_tdf2_filter_unit #(
  parameter int CHANNELS    = bqd_pkg::CHANNELS_DEF,
  parameter int SAMPLE_BITS = bqd_pkg::SAMPLE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  bqd_in_if.sink     in_ch,
  bqd_out_if.source  out_ch,
  bqd_cfg_if.sink    cfg
);
  import bqd_pkg::*;

  localparam int STATE_BITS = SAMPLE_BITS + STATE_EXTRA;
  localparam int CH_BITS    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int MODW       = (CH_BITS + 1 > CHAN_BITS) ? CH_BITS + 1 : CHAN_BITS;
  localparam int RND_BITS   = STATE_BITS - GUARD_BITS + 1;
  localparam logic [STATE_BITS:0] ROUND_HALF = (STATE_BITS + 1)'(1) << (GUARD_BITS - 1);

  // configuration registers
  logic signed [COEF_BITS-1:0] coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;

  // item registers
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic [CHAN_BITS-1:0]          chan_q;
  logic [CH_BITS-1:0]            ch_q;
  logic [MODW-1:0]               ch_mod;

  // channel state memory
  logic signed [STATE_BITS-1:0] d1_mem [CHANNELS];
  logic signed [STATE_BITS-1:0] d2_mem [CHANNELS];
  logic [CHANNELS-1:0]          chan_valid;
  logic signed [STATE_BITS-1:0] d1_rd, d2_rd;
  logic                         rd_ok;
  logic signed [STATE_BITS-1:0] d1_eff, d2_eff;

  // datapath
  ctl_t                          ctl;
  logic                          ready;
  logic                          in_acc;
  logic                          out_free;
  logic signed [MUL_BITS-1:0]    mul_coef, mul_opnd;
  logic signed [PROD_BITS-1:0]   prod;
  logic signed [ACC_BITS-1:0]    px, plo;
  logic signed [ACC_BITS-1:0]    acc_q;
  logic signed [STATE_BITS-1:0]  y_q, s1_q, s2_sat;
  logic [STATE_BITS:0]           y_rnd;
  logic [RND_BITS-1:0]           y_sh;
  logic [RND_BITS-SAMPLE_BITS:0] y_hi;
  logic signed [SAMPLE_BITS-1:0] y_out;

  // output register
  logic                          out_valid_q;
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic [CHAN_BITS-1:0]          chan_out_q;

  function automatic logic signed [STATE_BITS-1:0] sat_state(
    input logic signed [ACC_BITS-1:0] v
  );
    logic [ACC_BITS-STATE_BITS:0] up;
    up = v[ACC_BITS-1:STATE_BITS-1];
    if ((&up) || !(|up)) begin
      return v[STATE_BITS-1:0];
    end else if (v[ACC_BITS-1]) begin
      return {1'b1, {(STATE_BITS-1){1'b0}}};
    end else begin
      return {1'b0, {(STATE_BITS-1){1'b1}}};
    end
  endfunction

  // register writes; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      coef_b0 <= '0;
      coef_b1 <= '0;
      coef_b2 <= '0;
      coef_a1 <= '0;
      coef_a2 <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CF_B0:   coef_b0 <= cfg.data;
        CF_B1:   coef_b1 <= cfg.data;
        CF_B2:   coef_b2 <= cfg.data;
        CF_A1:   coef_a1 <= cfg.data;
        CF_A2:   coef_a2 <= cfg.data;
        default: ;
      endcase
    end
  end

  // input handshake and channel fold into the state range
  assign in_ch.ready = ready;
  assign in_acc      = in_ch.valid && ready;
  assign out_free    = !out_valid_q || out_ch.ready;

  always_comb begin
    ch_mod = MODW'(in_ch.chan);
    for (int i = 0; i < 7; i++) begin
      if (ch_mod >= MODW'(CHANNELS)) ch_mod = ch_mod - MODW'(CHANNELS);
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      x_q    <= in_ch.sample_in;
      chan_q <= in_ch.chan;
      ch_q   <= ch_mod[CH_BITS-1:0];
    end
  end

  bqd_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .start    (in_acc),
    .out_free (out_free),
    .ready    (ready),
    .ctl      (ctl)
  );

  // multiplier operand select
  always_comb begin
    case (ctl.coef_sel)
      CF_B0:   mul_coef = coef_b0;
      CF_B1:   mul_coef = coef_b1;
      CF_B2:   mul_coef = coef_b2;
      CF_A1:   mul_coef = coef_a1;
      CF_A2:   mul_coef = coef_a2;
      default: mul_coef = '0;
    endcase
    case (ctl.opnd)
      OPND_X:  mul_opnd = MUL_BITS'(x_q);
      OPND_YH: mul_opnd = MUL_BITS'($signed(y_q[STATE_BITS-1:COEF_FRAC]));
      OPND_YL: mul_opnd = MUL_BITS'({1'b0, y_q[COEF_FRAC-1:0]});
      default: mul_opnd = '0;
    endcase
  end

  bqd_mul u_mul (
    .clk  (clk),
    .en   (ctl.mul_en),
    .coef (mul_coef),
    .opnd (mul_opnd),
    .prod (prod)
  );

  // state memory: registered read, valid bits stand in for a clear
  always_ff @(posedge clk) begin
    if (ctl.read_en) begin
      d1_rd <= d1_mem[ch_q];
      d2_rd <= d2_mem[ch_q];
      rd_ok <= chan_valid[ch_q];
    end
    if (ctl.finish) begin
      d1_mem[ch_q] <= s1_q;
      d2_mem[ch_q] <= s2_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      chan_valid <= '0;
    end else if (ctl.finish) begin
      chan_valid[ch_q] <= 1'b1;
    end
  end

  assign d1_eff = rd_ok ? d1_rd : '0;
  assign d2_eff = rd_ok ? d2_rd : '0;

  // product scaling: x terms to state format, y low half floored by 2^28
  assign px     = prod >>> X_SHIFT;
  assign plo    = prod >>> COEF_FRAC;
  assign s2_sat = sat_state(acc_q);

  // accumulator
  always_ff @(posedge clk) begin
    case (ctl.acc_op)
      ACC_Y:       y_q   <= sat_state(px + ACC_BITS'(d1_eff));
      ACC_LOAD_D2: acc_q <= px + ACC_BITS'(d2_eff);
      ACC_LOAD_X:  acc_q <= px;
      ACC_SUB_HI:  acc_q <= acc_q - prod;
      ACC_SUB_LO:  acc_q <= acc_q - plo;
      default:     ;
    endcase
    if (ctl.s1_save) begin
      s1_q <= sat_state(acc_q);
    end
  end

  // round half up to sample format, then saturate
  assign y_rnd = {y_q[STATE_BITS-1], y_q} + ROUND_HALF;
  assign y_sh  = y_rnd[STATE_BITS:GUARD_BITS];
  assign y_hi  = y_sh[RND_BITS-1:SAMPLE_BITS-1];

  always_comb begin
    if ((&y_hi) || !(|y_hi)) begin
      y_out = y_sh[SAMPLE_BITS-1:0];
    end else if (y_sh[RND_BITS-1]) begin
      y_out = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y_out = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid_q <= 1'b0;
    end else if (ctl.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      sample_out_q <= y_out;
      chan_out_q   <= chan_q;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.sample_out = sample_out_q;
  assign out_ch.chan_out   = chan_out_q;

  `ASSERT_SAME(a_no_overwrite, clk, rst, ctl.finish, !out_valid_q || out_ch.ready, "output beat overwritten")
  `ASSERT_NEXT(a_finish_out, clk, rst, ctl.finish, out_ch.valid && chan_valid[ch_q], "finish without output or state update")

endmodule

FILE: verif/biquad_tdf2_filter_unit_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// biquad_tdf2_filter_unit_tb
// Self-checking bench for the multichannel transposed direct form II biquad.
// A bit-exact fixed-point predictor with its own coefficient and per-channel
// delay state produces the expected output beat for every accepted sample.
// Directed cases cover zero, unity and half gain, rounding, saturation and
// ignored register indexes. Random filters follow, with random idling on both
// channels, one stretch with no idling and one long output hold-off.
// ---------------------------------------------------------------------------
module biquad_tdf2_filter_unit_tb;
  import bqd_pkg::*;

  localparam int SMP_W       = SAMPLE_BITS_DEF;
  localparam int STATE_W     = SAMPLE_BITS_DEF + STATE_EXTRA;
  localparam int IDLE_PCT    = 33;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam int B_SPAN      = 1 << (COEF_FRAC - 1);  // +-0.5
  localparam int A1_SPAN     = 1 << (COEF_FRAC + 1);  // +-2.0
  localparam int A2_SPAN     = 1 << COEF_FRAC;        // +-1.0

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_ONE  = 1 << COEF_FRAC;
  localparam logic signed [COEF_BITS-1:0] COEF_HALF = 1 << (COEF_FRAC - 1);
  localparam logic signed [COEF_BITS-1:0] COEF_MAX  = {1'b0, {(COEF_BITS-1){1'b1}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MIN  = {1'b1, {(COEF_BITS-1){1'b0}}};

  typedef logic signed [95:0] wide_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] sample;
    logic [CHAN_BITS-1:0]    chan;
  } filt_beat_t;

  logic clk;
  logic rst;

  bqd_in_if  in_bus();
  bqd_out_if out_bus();
  bqd_cfg_if cfg_bus();

  biquad_tdf2_filter_unit DUT (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg    (cfg_bus)
  );

  // predictor state
  logic signed [COEF_BITS-1:0] coef_shadow [NUM_COEFS];
  logic signed [STATE_W-1:0]   s1_state [CHANNELS_DEF];
  logic signed [STATE_W-1:0]   s2_state [CHANNELS_DEF];

  filt_beat_t filt_pending[$];
  int         errors;
  int         cycle_cnt;
  int         hold_left;
  bit         gaps_on;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("biquad_tdf2_filter_unit_tb NOT OK");
      $finish;
    end
  end

  // output ready: long hold-off when requested, else random stalls while gaps are on
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      out_bus.ready <= !(gaps_on && $urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
    errors++;
  endtask

  // output beat checker
  always @(posedge clk) begin : check_out
    filt_beat_t want;
    if (!rst && out_bus.valid && out_bus.ready) begin
      if (filt_pending.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat chan %0d sample %0d",
                                out_bus.chan_out, out_bus.sample_out));
      end else begin
        want = filt_pending.pop_front();
        if (out_bus.sample_out !== want.sample)
          flag_mismatch($sformatf("chan %0d sample got %0d want %0d", want.chan,
                                  out_bus.sample_out, want.sample));
        if (out_bus.chan_out !== want.chan)
          flag_mismatch($sformatf("chan_out got %0d want %0d",
                                  out_bus.chan_out, want.chan));
      end
    end
  end

  function automatic wide_t clamp(input wide_t v, input int bits);
    wide_t hi, lo;
    hi = (96'sd1 <<< (bits - 1)) - 96'sd1;
    lo = -hi - 96'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // one TDF-II step: y = b0*x + s1, then s1/s2 update with saturated y
  function automatic filt_beat_t filter_step(input logic signed [SMP_W-1:0] x,
                                             input logic [CHAN_BITS-1:0] ch);
    wide_t xw, yw, b0, b1, b2, a1, a2, d1, d2, s1, s2, out_w;
    int idx;
    filt_beat_t beat;
    idx = ch % CHANNELS_DEF;
    xw  = wide_t'(x);
    b0  = wide_t'(coef_shadow[CF_B0]);
    b1  = wide_t'(coef_shadow[CF_B1]);
    b2  = wide_t'(coef_shadow[CF_B2]);
    a1  = wide_t'(coef_shadow[CF_A1]);
    a2  = wide_t'(coef_shadow[CF_A2]);
    d1  = wide_t'(s1_state[idx]);
    d2  = wide_t'(s2_state[idx]);
    yw  = clamp(((b0 * xw) >>> X_SHIFT) + d1, STATE_W);
    s1  = ((b1 * xw) >>> X_SHIFT) - ((a1 * yw) >>> COEF_FRAC) + d2;
    s2  = ((b2 * xw) >>> X_SHIFT) - ((a2 * yw) >>> COEF_FRAC);
    s1_state[idx] = STATE_W'(clamp(s1, STATE_W));
    s2_state[idx] = STATE_W'(clamp(s2, STATE_W));
    // round half up into the sample format, then saturate
    out_w = clamp((yw + (96'sd1 <<< (GUARD_BITS - 1))) >>> GUARD_BITS, SMP_W);
    beat.sample = out_w[SMP_W-1:0];
    beat.chan   = ch;
    return beat;
  endfunction

  function automatic logic signed [SMP_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return SMP_MAX;
      1: return SMP_MIN;
      2: return SMP_W'(int'($urandom_range(0, 511)) - 256);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic signed [COEF_BITS-1:0] rand_coef(input bit tame, input int span);
    if (!tame) return $urandom;
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [CHAN_BITS-1:0] random_chan();
    return CHAN_BITS'($urandom_range(0, 7));
  endfunction

  // one input beat; prediction is taken at the accepting edge
  task automatic send_sample(input logic signed [SMP_W-1:0] x,
                             input logic [CHAN_BITS-1:0] ch);
    while (gaps_on && $urandom_range(0, 99) < IDLE_PCT) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.sample_in <= x;
    in_bus.chan      <= ch;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    filt_pending.push_back(filter_step(x, ch));
    @(negedge clk);
  endtask

  // wait until every pending output beat has arrived
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (filt_pending.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  // leaves valid high so back-to-back writes need no re-assert
  task automatic write_coef(input logic [CFG_IDX_BITS-1:0] idx,
                            input logic [COEF_BITS-1:0] val);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data  <= val;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    if (idx < NUM_COEFS) coef_shadow[idx] = val;
    @(negedge clk);
  endtask

  task automatic set_coefs(input logic signed [COEF_BITS-1:0] b0, b1, b2, a1, a2);
    settle();
    write_coef(CF_B0, b0);
    write_coef(CF_B1, b1);
    write_coef(CF_B2, b2);
    write_coef(CF_A1, a1);
    write_coef(CF_A2, a2);
    cfg_bus.valid <= 1'b0;
  endtask

  // coefficients at reset are zero: output is zero
  task automatic test_reset_coefs();
    send_sample(SMP_MAX, 0);
    send_sample(SMP_MIN, 7);
  endtask

  // unity b0 passes the sample through exactly
  task automatic test_passthrough();
    set_coefs(COEF_ONE, '0, '0, '0, '0);
    send_sample(SMP_MAX, 0);
    send_sample(SMP_MIN, 1);
    send_sample('0, 2);
    send_sample(SMP_W'(-1), 3);
    send_sample(1, 4);
  endtask

  // half gain lands odd samples exactly on the rounding midpoint
  task automatic test_rounding();
    set_coefs(COEF_HALF, '0, '0, '0, '0);
    send_sample(1, 5);
    send_sample(SMP_W'(-1), 5);
    send_sample(3, 5);
    send_sample(SMP_W'(-3), 5);
  endtask

  // extreme coefficients drive output and state saturation
  task automatic test_saturation();
    set_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SMP_MAX, 6);
    send_sample(SMP_MAX, 6);
    send_sample(SMP_MIN, 6);
    set_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    send_sample(SMP_MIN, 7);
    send_sample(SMP_MAX, 7);
    send_sample(SMP_MAX, 6);
  endtask

  // writes past the last coefficient index must change nothing
  task automatic test_unknown_index();
    logic [CFG_IDX_BITS-1:0] idx;
    settle();
    for (int i = NUM_COEFS; i < (1 << CFG_IDX_BITS); i++) begin
      idx = CFG_IDX_BITS'(i);
      write_coef(idx, $urandom);
    end
    cfg_bus.valid <= 1'b0;
    send_sample(random_sample(), 0);
    send_sample(random_sample(), 1);
    send_sample(random_sample(), 2);
  endtask

  // random filters, alternating bounded and fully random coefficient sets
  task automatic test_random_filters();
    bit tame;
    for (int ph = 0; ph < 5; ph++) begin
      tame = ph[0];
      set_coefs(rand_coef(tame, B_SPAN), rand_coef(tame, B_SPAN), rand_coef(tame, B_SPAN),
                rand_coef(tame, A1_SPAN), rand_coef(tame, A2_SPAN));
      repeat (110) send_sample(random_sample(), random_chan());
    end
  endtask

  // back-to-back beats, no idling on either side
  task automatic test_streaming();
    set_coefs(rand_coef(1, B_SPAN), rand_coef(1, B_SPAN), rand_coef(1, B_SPAN),
              rand_coef(1, A1_SPAN), rand_coef(1, A2_SPAN));
    gaps_on = 1'b0;
    repeat (150) send_sample(random_sample(), random_chan());
    settle();
    gaps_on = 1'b1;
  endtask

  // output held off for a long stretch while samples keep coming
  task automatic test_backpressure();
    set_coefs(rand_coef(1, B_SPAN), rand_coef(1, B_SPAN), rand_coef(1, B_SPAN),
              rand_coef(1, A1_SPAN), rand_coef(1, A2_SPAN));
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    @(negedge clk);
    repeat (50) send_sample(random_sample(), random_chan());
  endtask

  initial begin
    rst               = 1'b1;
    in_bus.valid      = 1'b0;
    in_bus.sample_in  = '0;
    in_bus.chan       = '0;
    out_bus.ready     = 1'b0;
    cfg_bus.valid     = 1'b0;
    cfg_bus.index     = '0;
    cfg_bus.data      = '0;
    errors            = 0;
    cycle_cnt         = 0;
    hold_left         = 0;
    gaps_on           = 1'b1;
    for (int i = 0; i < NUM_COEFS; i++) coef_shadow[i] = '0;
    for (int i = 0; i < CHANNELS_DEF; i++) begin
      s1_state[i] = '0;
      s2_state[i] = '0;
    end

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_reset_coefs();
    test_passthrough();
    test_rounding();
    test_saturation();
    test_unknown_index();
    test_random_filters();
    test_streaming();
    test_backpressure();
    settle();

    if (errors == 0) begin
      $display("biquad_tdf2_filter_unit_tb OK");
    end else begin
      $display("biquad_tdf2_filter_unit_tb NOT OK");
    end
    $finish;
  end

endmodule

FILE: biquad_tdf2_filter_unit.f
+incdir+rtl/core
rtl/core/bqd_pkg.sv
rtl/core/bqd_ifs.sv
rtl/core/bqd_mul.sv
rtl/core/bqd_seq.sv
rtl/core/biquad_tdf2_filter_unit.sv
verif/biquad_tdf2_filter_unit_tb.sv
